>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Each macro builds one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jsu_pkg.sv
// Types, character codes and helper functions of the JSON string unescaper.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package jsu_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChNewline   = 8'h0a;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_HEX
  } mode_e;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_DONE,
    CMD_ERROR,
    CMD_CODE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    STATUS_RUN   = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_e;

  // One decoded request from the front: a literal byte, a code point, or a status.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] code;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    status_e    status;
    logic       last;
  } beat_t;

  // Escape letter after a backslash: bit 8 says the letter is a simple escape.
  function automatic logic [8:0] esc_map(input logic [7:0] b);
    logic [8:0] r;
    r = 9'h000;
    unique case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

  // Hex digit of either case: bit 4 says the byte is a digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: front end, request queue and UTF-8 back end.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
//   Port group   Dir  Content
//   s_axis_*     in   tdata[7:0] = in_byte
//   m_axis_*     out  tdata[7:0] = out_byte, tuser[0] = has_byte, tuser[2:1] = status,
//                     tlast = last
//
// One input byte is taken per cycle while the queue is not full; the first output beat of a
// request is loaded into the output register when the back end takes it at the queue head,
// and further beats follow one per cycle while the output is ready. A \u escape that expands
// to two or three UTF-8 bytes holds the back end for one beat per byte, so the queue can fill
// and input stalls. Reset puts the decoder in plain mode and empties the queue.
// Output stalls hold the output register and back up through the queue to s_axis_tready.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,   // [0] has_byte, [2:1] status
  output logic            m_axis_tlast
);
  import jsu_pkg::*;

  cmd_t  push_cmd, head_cmd;
  logic  push, full, head_valid, pop, accept;
  beat_t beat;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .cmd_o    (push_cmd),
    .push_o   (push)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .beat_o      (beat)
  );

  assign m_axis_tdata = beat.data;
  assign m_axis_tuser = {beat.status, beat.has_byte};
  assign m_axis_tlast = beat.last;

endmodule

`default_nettype wire

>>> rtl/jsu_front.sv
// Front end: accepts input bytes, tracks escape and hex state, and issues decode requests.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_i,
  output jsu_pkg::cmd_t      cmd_o,
  output logic               push_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  count_q, count_d;
  logic [15:0] accum_q, accum_d;
  logic [8:0]  esc;
  logic [4:0]  hex;

  always_comb begin
    esc     = esc_map(byte_i);
    hex     = hex_digit(byte_i);
    mode_d  = mode_q;
    count_d = count_q;
    accum_d = accum_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: CMD_BYTE, code: {8'h00, byte_i}};
    if (accept_i) begin
      if (byte_i == ChNul) begin
        mode_d  = MODE_PLAIN;
        count_d = 2'd0;
        accum_d = 16'h0000;
        push_o  = 1'b1;
        cmd_o   = '{kind: CMD_ERROR, code: 16'h0000};
      end else begin
        unique case (mode_q)
          MODE_ESC: begin
            if (esc[8]) begin
              mode_d = MODE_PLAIN;
              push_o = 1'b1;
              cmd_o  = '{kind: CMD_BYTE, code: {8'h00, esc[7:0]}};
            end else if (byte_i == ChU) begin
              mode_d  = MODE_HEX;
              count_d = 2'd0;
              accum_d = 16'h0000;
            end else begin
              mode_d  = MODE_PLAIN;
              count_d = 2'd0;
              accum_d = 16'h0000;
              push_o  = 1'b1;
              cmd_o   = '{kind: CMD_ERROR, code: 16'h0000};
            end
          end
          MODE_HEX: begin
            if (!hex[4]) begin
              mode_d  = MODE_PLAIN;
              count_d = 2'd0;
              accum_d = 16'h0000;
              push_o  = 1'b1;
              cmd_o   = '{kind: CMD_ERROR, code: 16'h0000};
            end else if (count_q == 2'd3) begin
              mode_d  = MODE_PLAIN;
              count_d = 2'd0;
              accum_d = 16'h0000;
              push_o  = 1'b1;
              cmd_o   = '{kind: CMD_CODE, code: {accum_q[11:0], hex[3:0]}};
            end else begin
              count_d = count_q + 2'd1;
              accum_d = {accum_q[11:0], hex[3:0]};
            end
          end
          default: begin
            if (byte_i == ChQuote) begin
              count_d = 2'd0;
              accum_d = 16'h0000;
              push_o  = 1'b1;
              cmd_o   = '{kind: CMD_DONE, code: {8'h00, ChNewline}};
            end else if (byte_i == ChBackslash) begin
              mode_d = MODE_ESC;
            end else begin
              push_o = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      count_q <= 2'd0;
      accum_q <= 16'h0000;
    end else begin
      mode_q  <= mode_d;
      count_q <= count_d;
      accum_q <= accum_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsu_fifo.sv
// Short request queue between the front end and the back end.
// Depends on jsu_pkg for the request type.
`default_nettype none

module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jsu_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output jsu_pkg::cmd_t      cmd_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsu_back.sv
// Back end: expands each request into one to three output beats, UTF-8 encoding code points.
// Depends on jsu_pkg; drives the output register of the block.
`default_nettype none

module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire jsu_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output jsu_pkg::beat_t     beat_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [1:0] last_idx;
  logic       valid_q, valid_d;
  logic       load;
  beat_t      beat_q, beat_d;
  logic [15:0] cp;

  assign cp          = cmd_i.code;
  assign load        = cmd_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

  always_comb begin
    last_idx = 2'd0;
    beat_d   = '{data: cp[7:0], has_byte: 1'b1, status: STATUS_RUN, last: 1'b1};
    unique case (cmd_i.kind)
      CMD_DONE: begin
        beat_d.data   = ChNewline;
        beat_d.status = STATUS_DONE;
      end
      CMD_ERROR: begin
        beat_d.data     = 8'h00;
        beat_d.has_byte = 1'b0;
        beat_d.status   = STATUS_ERROR;
      end
      CMD_CODE: begin
        if (cp <= 16'h007f) begin
          last_idx = 2'd0;
        end else if (cp <= 16'h07ff) begin
          last_idx = 2'd1;
          beat_d.data = (idx_q == 2'd0) ? (8'hc0 | {3'b000, cp[10:6]})
                                        : (8'h80 | {2'b00, cp[5:0]});
        end else begin
          last_idx = 2'd2;
          priority case (idx_q)
            2'd0:    beat_d.data = 8'he0 | {4'h0, cp[15:12]};
            2'd1:    beat_d.data = 8'h80 | {2'b00, cp[11:6]};
            default: beat_d.data = 8'h80 | {2'b00, cp[5:0]};
          endcase
        end
        beat_d.last = (idx_q == last_idx);
      end
      default: begin
        beat_d.status = STATUS_RUN;
      end
    endcase
  end

  assign pop_o = load && beat_d.last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = beat_d.last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on assert_macros.svh and jsu_pkg.
`default_nettype none
`include "assert_macros.svh"

module jsu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);
  import jsu_pkg::*;

  logic        stall;
  logic [11:0] payload;
  logic        is_error, is_done, error_ok, done_ok;

  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign payload  = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign is_error = m_axis_tvalid && (m_axis_tuser[2:1] == STATUS_ERROR);
  assign is_done  = m_axis_tvalid && (m_axis_tuser[2:1] == STATUS_DONE);
  assign error_ok = m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata == 8'h00);
  assign done_ok  = m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == ChNewline);

  `ASSERT_NEXT(a_stall_holds_valid, clk_i, rst_ni, stall, m_axis_tvalid, "valid dropped")
  `ASSERT_NEXT(a_stall_holds_data, clk_i, rst_ni, stall, $stable(payload), "payload changed")
  `ASSERT_IMPL(a_error_shape, clk_i, rst_ni, is_error, error_ok, "bad error beat")
  `ASSERT_IMPL(a_done_shape, clk_i, rst_ni, is_done, done_ok, "bad done beat")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
// Drives string body bytes on s_axis, predicts the decoded beats and checks m_axis.
// Depends on jsu_pkg and json_string_unescape_utf8 from the RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int unsigned RandomItems = 200;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned DrainLimit  = 20000;

  // Escape letters and the control bytes they stand for.
  localparam logic [7:0] LtrB   = 8'h62;
  localparam logic [7:0] LtrF   = 8'h66;
  localparam logic [7:0] LtrN   = 8'h6e;
  localparam logic [7:0] LtrR   = 8'h72;
  localparam logic [7:0] LtrT   = 8'h74;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlFf  = 8'h0c;
  localparam logic [7:0] CtlCr  = 8'h0d;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] EscLetters [8] = '{ChQuote, ChBackslash, ChSlash,
                                            LtrB, LtrF, LtrN, LtrR, LtrT};

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    status_e    status;
    logic       last;
  } decoded_beat_t;

  typedef struct packed {
    logic       pause;
    logic [7:0] data;
  } body_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;     // [7:0] in_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic [2:0] m_axis_tuser;          // [0] has_byte, [2:1] status
  logic       m_axis_tlast;

  json_string_unescape_utf8 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  body_item_t    body_q[$];
  decoded_beat_t decoded_q[$];

  // Decoder state as seen from the outside.
  mode_e       dec_mode = MODE_PLAIN;
  logic [1:0]  dec_digits = '0;
  logic [15:0] dec_code = '0;

  int unsigned total_bytes = 0;
  int unsigned bytes_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned mismatches = 0;
  int unsigned n_done = 0;
  int unsigned n_error = 0;
  int unsigned n_multi = 0;
  int unsigned cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_armed = 1'b1;

  function automatic void push_beat(input logic [7:0] d, input logic h, input status_e s,
                                    input logic l);
    decoded_q.push_back('{d, h, s, l});
  endfunction

  function automatic void push_error();
    dec_mode   = MODE_PLAIN;
    dec_digits = '0;
    dec_code   = '0;
    n_error++;
    push_beat(8'h00, 1'b0, STATUS_ERROR, 1'b1);
  endfunction

  // Works out the beats that one accepted body byte produces.
  function automatic void decode_byte(input logic [7:0] b);
    logic [4:0]  nib;
    logic [15:0] cp;
    nib = '0;
    cp  = '0;
    if (b == ChNul) begin
      push_error();
      return;
    end
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_PLAIN;
        case (b)
          ChQuote, ChBackslash, ChSlash: push_beat(b, 1'b1, STATUS_RUN, 1'b1);
          LtrB: push_beat(CtlBs, 1'b1, STATUS_RUN, 1'b1);
          LtrF: push_beat(CtlFf, 1'b1, STATUS_RUN, 1'b1);
          LtrN: push_beat(ChNewline, 1'b1, STATUS_RUN, 1'b1);
          LtrR: push_beat(CtlCr, 1'b1, STATUS_RUN, 1'b1);
          LtrT: push_beat(CtlTab, 1'b1, STATUS_RUN, 1'b1);
          ChU: begin
            dec_mode   = MODE_HEX;
            dec_digits = '0;
            dec_code   = '0;
          end
          default: push_error();
        endcase
      end
      MODE_HEX: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          nib = {1'b1, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
          nib = {1'b1, b[3:0] + 4'd9};
        end
        if (!nib[4]) begin
          push_error();
        end else begin
          dec_code = {dec_code[11:0], nib[3:0]};
          if (dec_digits == 2'd3) begin
            cp         = dec_code;
            dec_mode   = MODE_PLAIN;
            dec_digits = '0;
            dec_code   = '0;
            if (cp <= 16'h007f) begin
              push_beat(cp[7:0], 1'b1, STATUS_RUN, 1'b1);
            end else if (cp <= 16'h07ff) begin
              n_multi++;
              push_beat(8'hc0 | {3'b000, cp[10:6]}, 1'b1, STATUS_RUN, 1'b0);
              push_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1, STATUS_RUN, 1'b1);
            end else begin
              n_multi++;
              push_beat(8'he0 | {4'h0, cp[15:12]}, 1'b1, STATUS_RUN, 1'b0);
              push_beat(8'h80 | {2'b00, cp[11:6]}, 1'b1, STATUS_RUN, 1'b0);
              push_beat(8'h80 | {2'b00, cp[5:0]}, 1'b1, STATUS_RUN, 1'b1);
            end
          end else begin
            dec_digits = dec_digits + 2'd1;
          end
        end
      end
      default: begin
        dec_mode = MODE_PLAIN;
        if (b == ChQuote) begin
          dec_digits = '0;
          dec_code   = '0;
          n_done++;
          push_beat(ChNewline, 1'b1, STATUS_DONE, 1'b1);
        end else if (b == ChBackslash) begin
          dec_mode = MODE_ESC;
        end else begin
          push_beat(b, 1'b1, STATUS_RUN, 1'b1);
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    body_q.push_back('{1'b0, b});
    total_bytes++;
  endtask

  task automatic add_pause();
    body_q.push_back('{1'b1, 8'h00});
  endtask

  task automatic add_code_point(input logic [15:0] cp);
    add_byte(ChBackslash);
    add_byte(ChU);
    add_byte(hex_char(cp[15:12]));
    add_byte(hex_char(cp[11:8]));
    add_byte(hex_char(cp[7:4]));
    add_byte(hex_char(cp[3:0]));
  endtask

  // Sender: one body byte per beat, a random gap after each one while bit 5 of the sent count is clear.
  always @(posedge clk_i or negedge rst_ni) begin : sender
    body_item_t  nxt;
    int unsigned wait_n;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap        <= 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        decode_byte(s_axis_tdata);
        bytes_sent <= bytes_sent + 1;
      end
      if (tx_gap != 0) begin
        tx_gap        <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (body_q.size() != 0 && body_q[0].pause) begin
        // Hold back until every predicted beat has come out.
        if (decoded_q.size() == 0) body_q.delete(0);
        s_axis_tvalid <= 1'b0;
      end else if (body_q.size() != 0) begin
        nxt = body_q.pop_front();
        wait_n = bytes_sent[5] ? 0 : $urandom_range(0, 15);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        tx_gap        <= wait_n;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off so that the queue fills and s_axis_tready drops.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && bytes_sent >= 60) begin
      hold_left  <= HoldCycles;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    decoded_beat_t want;
    int unsigned   wait_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen <= beats_seen + 1;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected beat: data=%02h tuser=%03b last=%0b", $realtime,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata != want.data || m_axis_tuser[0] != want.has_byte ||
              m_axis_tuser[2:1] != want.status || m_axis_tlast != want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] beat mismatch: expected data=%02h has=%0b status=%0d last=%0b,",
                       $realtime, want.data, want.has_byte, want.status, want.last,
                       " got data=%02h has=%0b status=%0d last=%0b", m_axis_tdata,
                       m_axis_tuser[0], m_axis_tuser[2:1], m_axis_tlast);
          end
        end
        wait_n = beats_seen[5] ? 0 : $urandom_range(0, 15);
        rx_gap        <= wait_n;
        m_axis_tready <= (wait_n == 0) && (hold_left == 0);
      end else if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap        <= rx_gap - 1;
        m_axis_tready <= (rx_gap == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("json_string_unescape_utf8 verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned k;
    logic [7:0]  b;
    logic        paused_mid;
    paused_mid = 1'b0;

    // Directed: byte extremes, a bad escape, code point zero, the top code point
    // in mixed case, a bad hex digit, the closing quote and the zero byte.
    add_byte(8'h01);
    add_byte(8'hff);
    add_byte(ChBackslash);
    add_byte(8'h71);
    add_code_point(16'h0000);
    add_code_point(16'hffff);
    add_byte(ChBackslash);
    add_byte(ChU);
    add_byte(8'h30);
    add_byte(8'h37);
    add_byte(8'h67);
    add_byte(ChQuote);
    add_byte(ChNul);
    add_pause();

    // Random: mostly well-formed pieces of string bodies, the rest malformed.
    k = total_bytes;
    while (total_bytes - k < RandomItems) begin
      if (!paused_mid && total_bytes - k >= RandomItems / 2) begin
        add_pause();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        b = 8'($urandom_range(1, 255));
        if (b == ChQuote || b == ChBackslash) b = b ^ 8'h01;
        add_byte(b);
      end else if (pick < 50) begin
        add_byte(ChBackslash);
        add_byte(EscLetters[$urandom_range(0, 7)]);
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0: add_code_point(16'($urandom_range(0, 16'h007f)));
          1: add_code_point(16'($urandom_range(16'h0080, 16'h07ff)));
          default: add_code_point(16'($urandom_range(16'h0800, 16'hffff)));
        endcase
      end else if (pick < 83) begin
        add_byte(ChQuote);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            b = 8'($urandom_range(1, 255));
            foreach (EscLetters[i]) if (b == EscLetters[i]) b = 8'h78;
            if (b == ChU) b = 8'h78;
            add_byte(ChBackslash);
            add_byte(b);
          end
          1: begin
            add_byte(ChBackslash);
            add_byte(ChU);
            repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
            b = 8'($urandom_range(1, 255));
            if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                (b >= 8'h61 && b <= 8'h66)) b = 8'h67;
            add_byte(b);
          end
          2: begin
            // Zero byte in plain, escape or hex mode.
            pick = $urandom_range(0, 2);
            if (pick != 0) add_byte(ChBackslash);
            if (pick == 2) begin
              add_byte(ChU);
              repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
            end
            add_byte(ChNul);
          end
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end

    @(posedge rst_ni);
    while (bytes_sent != total_bytes) @(posedge clk_i);
    k = 0;
    while (decoded_q.size() != 0 && k < DrainLimit) begin
      @(posedge clk_i);
      k++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $display("%0d predicted beats never arrived", decoded_q.size());
      mismatches += decoded_q.size();
    end
    $display("Sent %0d body bytes and checked %0d output beats in %0d cycles.",
             bytes_sent, beats_seen, cycles);
    $display("Seen: %0d closed strings, %0d malformed inputs, %0d multi-byte code points.",
             n_done, n_error, n_multi);
    if (mismatches == 0) begin
      $display("json_string_unescape_utf8 verification clean");
    end else begin
      $display("json_string_unescape_utf8 verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
